// File: rtl/eplt_pkg.sv
// Shared types and constants for the echo probe liveness tracker.
// Used by eplt_slot_alu and echo_probe_liveness_tracker_unit; no dependencies.
package eplt_pkg;

   // Capacity and fixed field widths
   localparam int MAX_SLOTS_DEF = 64;
   localparam int KIND_W        = 2;
   localparam int ROUND_W       = 16;
   localparam int SLOT_IN_W     = 16;
   localparam int SLOT_W        = 6;
   localparam int CNT_W         = 32;
   localparam int EPC_W         = 7;
   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 7;

   // Round number that means "no round yet"
   localparam logic [ROUND_W-1:0] NO_TICK = '0;

   // Event kinds on the request side
   localparam logic [KIND_W-1:0] EV_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] EV_REPLY = 2'd1;
   localparam logic [KIND_W-1:0] EV_CLOSE = 2'd2;

   // Result kinds on the response side
   localparam logic [KIND_W-1:0] RES_PROBE   = 2'd0;
   localparam logic [KIND_W-1:0] RES_VERDICT = 2'd1;
   localparam logic [KIND_W-1:0] RES_STATUS  = 2'd2;

   // Register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_PROBING_ENABLED = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENDPOINT_COUNT  = 1'd1;

   // Request word
   typedef struct packed {
      logic [KIND_W-1:0]    req_type;
      logic [ROUND_W-1:0]   reply_round;
      logic [SLOT_IN_W-1:0] reply_slot;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [SLOT_W-1:0]  slot_index;
      logic [ROUND_W-1:0] round_id;
      logic               reply_accepted;
      logic               answered_mark;
      logic [CNT_W-1:0]   miss_streak;
      logic [CNT_W-1:0]   probes_sent;
      logic [CNT_W-1:0]   answers_counted;
      logic               last_of_run;
   } rsp_word_type;

   // Per-slot record held in the slot RAM
   typedef struct packed {
      logic             answered;
      logic [CNT_W-1:0] miss;
      logic [CNT_W-1:0] sent;
      logic [CNT_W-1:0] answers;
   } slot_rec_type;

   // Control handed to the slot update unit
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              reply_ok;
   } alu_ctl_type;

endpackage

// File: rtl/eplt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eplt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/eplt_slot_alu.sv
// Shared slot update unit: one 32-bit incrementer serves probe, answer and miss counts.
// Depends on eplt_pkg.
module eplt_slot_alu (
   input  eplt_pkg::alu_ctl_type  ctl,
   input  eplt_pkg::slot_rec_type rec_in,
   output eplt_pkg::slot_rec_type rec_out,
   output logic                   accepted
);

   logic [eplt_pkg::CNT_W-1:0] opnd;
   logic [eplt_pkg::CNT_W-1:0] sum;

   // Pick the counter this event bumps
   always_comb begin
      case (ctl.kind)
         eplt_pkg::EV_TICK:  opnd = rec_in.sent;
         eplt_pkg::EV_REPLY: opnd = rec_in.answers;
         default:            opnd = rec_in.miss;
      endcase
   end

   assign sum      = opnd + eplt_pkg::CNT_W'(1);
   assign accepted = (ctl.kind == eplt_pkg::EV_REPLY) && ctl.reply_ok && !rec_in.answered;

   // Build the updated record
   always_comb begin
      rec_out = rec_in;
      case (ctl.kind)
         eplt_pkg::EV_TICK: begin
            rec_out.answered = 1'b0;
            rec_out.sent     = sum;
         end
         eplt_pkg::EV_REPLY: begin
            if (accepted) begin
               rec_out.answered = 1'b1;
               rec_out.answers  = sum;
               rec_out.miss     = '0;
            end
         end
         eplt_pkg::EV_CLOSE: begin
            // saturate the miss streak
            if (!rec_in.answered && (rec_in.miss != '1)) begin
               rec_out.miss = sum;
            end
         end
         default: begin
            rec_out = rec_in;
         end
      endcase
   end

endmodule

// File: rtl/echo_probe_liveness_tracker_unit.sv
// Echo probe liveness tracker: per-slot probe, answer and miss bookkeeping.
// Tick and window close walk the active slots through S_WALK and S_TAIL, one RAM read per slot,
// with results one per cycle; when they walk no slot they give no result. An in-range reply
// walks its one slot; an out-of-range reply is answered from idle with an empty record.
// A new word is accepted only while idle, so the walk for one word ends before the next is taken.
// Synchronous reset clears state, round, configuration registers and all slot records (valid
// bits); results cannot be stalled by the receiver. Depends on eplt_pkg, eplt_ram, eplt_slot_alu.
module echo_probe_liveness_tracker_unit #(
   parameter int MAX_SLOTS = eplt_pkg::MAX_SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  eplt_pkg::req_word_type             req_word,
   output logic                               rsp_strobe,
   output eplt_pkg::rsp_word_type             rsp_word,
   input  logic                               csr_we,
   input  logic [eplt_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [eplt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int REC_W = $bits(eplt_pkg::slot_rec_type);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_TAIL = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic                             enable_ff;
   logic [eplt_pkg::EPC_W-1:0]       epc_ff;
   logic [eplt_pkg::ROUND_W-1:0]     round_ff, round_in;
   logic [eplt_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic                             rok_ff, rok_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [IDX_W-1:0]                 last_ff, last_in;
   logic                             pend_ff, pend_in;
   logic [IDX_W-1:0]                 pidx_ff, pidx_in;
   logic                             plast_ff, plast_in;
   logic                             pvld_ff, pvld_in;
   logic [MAX_SLOTS-1:0]             vld_ff;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   eplt_pkg::rsp_word_type           rsp_word_ff, rsp_word_in;

   logic [eplt_pkg::ROUND_W-1:0]     act_n;
   logic [IDX_W-1:0]                 last_idx;
   logic [eplt_pkg::ROUND_W-1:0]     round_next;
   logic                             accept;
   logic                             in_range;
   logic                             epc_wr;
   logic [REC_W-1:0]                 ram_rd;
   eplt_pkg::slot_rec_type           rec_cur;
   eplt_pkg::slot_rec_type           rec_upd;
   eplt_pkg::alu_ctl_type            alu_ctl;
   logic                             alu_acc;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;
   assign epc_wr     = csr_we && (csr_addr == eplt_pkg::CSR_ENDPOINT_COUNT);

   // Active slot count, clamped to capacity
   assign act_n    = (eplt_pkg::ROUND_W'(epc_ff) > eplt_pkg::ROUND_W'(MAX_SLOTS))
                     ? eplt_pkg::ROUND_W'(MAX_SLOTS) : eplt_pkg::ROUND_W'(epc_ff);
   assign last_idx = IDX_W'(act_n - eplt_pkg::ROUND_W'(1));
   assign in_range = (req_word.reply_slot < act_n);

   // Next round, skipping the no-round value
   always_comb begin
      round_next = round_ff + eplt_pkg::ROUND_W'(1);
      if (round_next == eplt_pkg::NO_TICK) begin
         round_next = round_next + eplt_pkg::ROUND_W'(1);
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         epc_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            eplt_pkg::CSR_PROBING_ENABLED: enable_ff <= csr_wdata[0];
            eplt_pkg::CSR_ENDPOINT_COUNT:  epc_ff    <= csr_wdata;
            default:                       epc_ff    <= epc_ff;
         endcase
      end
   end

   // Sequencer: decode the word, then walk slots one RAM read per cycle
   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      kind_in       = kind_ff;
      rok_in        = rok_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      pend_in       = 1'b0;
      pidx_in       = idx_ff;
      plast_in      = (idx_ff == last_ff);
      pvld_in       = vld_ff[idx_ff];
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req_word.req_type;
               idx_in  = '0;
               last_in = last_idx;
               case (req_word.req_type)
                  eplt_pkg::EV_TICK: begin
                     if (enable_ff) begin
                        round_in = round_next;
                        if (act_n != '0) begin
                           state_in = S_WALK;
                        end
                     end
                  end
                  eplt_pkg::EV_REPLY: begin
                     rok_in = enable_ff && (round_ff != eplt_pkg::NO_TICK) &&
                              (req_word.reply_round == round_ff);
                     if (in_range) begin
                        idx_in   = IDX_W'(req_word.reply_slot);
                        last_in  = IDX_W'(req_word.reply_slot);
                        state_in = S_WALK;
                     end else begin
                        // out of range: reject at once with an empty record
                        rsp_strobe_in              = 1'b1;
                        rsp_word_in                = '0;
                        rsp_word_in.result_kind    = eplt_pkg::RES_VERDICT;
                        rsp_word_in.round_id       = round_ff;
                        rsp_word_in.last_of_run    = 1'b1;
                     end
                  end
                  eplt_pkg::EV_CLOSE: begin
                     if (enable_ff && (round_ff != eplt_pkg::NO_TICK) && (act_n != '0)) begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WALK: begin
            pend_in = 1'b1;
            if (idx_ff == last_ff) begin
               state_in = S_TAIL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_TAIL: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Emit the slot whose record arrived this cycle
      if (pend_ff) begin
         rsp_strobe_in               = 1'b1;
         rsp_word_in.slot_index      = eplt_pkg::SLOT_W'(pidx_ff);
         rsp_word_in.round_id        = round_ff;
         rsp_word_in.reply_accepted  = alu_acc;
         rsp_word_in.answered_mark   = rec_upd.answered;
         rsp_word_in.miss_streak     = rec_upd.miss;
         rsp_word_in.probes_sent     = rec_upd.sent;
         rsp_word_in.answers_counted = rec_upd.answers;
         rsp_word_in.last_of_run     = plast_ff;
         case (kind_ff)
            eplt_pkg::EV_TICK:  rsp_word_in.result_kind = eplt_pkg::RES_PROBE;
            eplt_pkg::EV_REPLY: rsp_word_in.result_kind = eplt_pkg::RES_VERDICT;
            default:            rsp_word_in.result_kind = eplt_pkg::RES_STATUS;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         round_ff      <= eplt_pkg::NO_TICK;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         round_ff      <= round_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      rok_ff      <= rok_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      pidx_ff     <= pidx_in;
      plast_ff    <= plast_in;
      pvld_ff     <= pvld_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Slot valid bits: an invalid slot reads as a cleared record
   always_ff @(posedge clock) begin
      if (reset || epc_wr) begin
         vld_ff <= '0;
      end else if (pend_ff) begin
         vld_ff[pidx_ff] <= 1'b1;
      end
   end

   eplt_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (pend_ff),
      .wr_addr (pidx_ff),
      .wr_data (rec_upd),
      .rd_en   (state_ff == S_WALK),
      .rd_addr (idx_ff),
      .rd_data (ram_rd)
   );

   assign rec_cur          = pvld_ff ? eplt_pkg::slot_rec_type'(ram_rd) : '0;
   assign alu_ctl.kind     = kind_ff;
   assign alu_ctl.reply_ok = rok_ff;

   eplt_slot_alu u_alu (
      .ctl      (alu_ctl),
      .rec_in   (rec_cur),
      .rec_out  (rec_upd),
      .accepted (alu_acc)
   );

   // A run ends only after the walk has fully drained
   a_last_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.last_of_run) |-> (state_ff == S_IDLE))
      else $error("last result seen while slot walk still active");

   // Results of one run come out on consecutive cycles
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.last_of_run) |=> rsp_strobe)
      else $error("gap inside a result run");

   // Probe and status results only exist once a round has started
   a_round_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.result_kind != eplt_pkg::RES_VERDICT))
      |-> (rsp_word.round_id != eplt_pkg::NO_TICK))
      else $error("probe or status result without a round");

   // No slot record is in flight while the block reports idle
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !pend_ff)
      else $error("pending slot record while idle");

endmodule
